// ----- hw/rtl/ray_sphere_intersect_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ray-sphere intersection block.
// Both macros expect clk and arst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_TOP_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define RSI_CHECK(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rsi check failed");

// When the first expression holds, the second holds in the next cycle.
`define RSI_CHECK_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rsi check failed");

`endif

// ----- hw/rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray-sphere intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned RADIUS_W   = 31;
	localparam int unsigned DIST_W     = 31;
	localparam int unsigned WIDE_W     = 66;
	localparam int unsigned DISC_W     = 132;
	localparam int unsigned FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                miss;
		logic [WIDE_W-1:0]   a;
		logic [WIDE_W-1:0]   bm;
		logic [DISC_W-1:0]   disc;
	} fq_t;

endpackage

// ----- hw/rtl/rsi_front.sv -----
// ----------------------------------------------------------------------------
// rsi_front
// Accepts rays, forms the quadratic coefficients and the discriminant, and
// marks the rays that miss early. Results enter the queue in order.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_W-1:0]   eye_x,
	input  logic signed [COORD_W-1:0]   eye_y,
	input  logic signed [COORD_W-1:0]   eye_z,
	input  logic signed [COORD_W-1:0]   aim_x,
	input  logic signed [COORD_W-1:0]   aim_y,
	input  logic signed [COORD_W-1:0]   aim_z,
	input  logic signed [COORD_W-1:0]   center_x,
	input  logic signed [COORD_W-1:0]   center_y,
	input  logic signed [COORD_W-1:0]   center_z,
	input  logic        [RADIUS_W-1:0]  sphere_radius,
	output logic                        push,
	input  logic                        full,
	output fq_t                         push_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [2:0][32:0] d_s1, e_s1;
	logic [RADIUS_W-1:0] r_s1;

	logic [2:0][64:0] aa_s2, ee_s2, ae_s2;
	logic [2:0]       neg_s2;
	logic [61:0]      rr_s2;

	logic [WIDE_W-1:0] a_s3, ee_s3, bpos_s3, bneg_s3;
	logic [61:0]       rr_s3;

	logic              miss_s4;
	logic [WIDE_W-1:0] a_s4, bm_s4, c_s4;

	logic              miss_s5;
	logic [WIDE_W-1:0] a_s5, bm_s5;
	logic [65:0]       bll_s5, blh_s5, bhh_s5, alcl_s5, alch_s5, ahcl_s5, ahch_s5;

	logic              miss_s6;
	logic [WIDE_W-1:0] a_s6, bm_s6;
	logic [DISC_W-1:0] p_s6, q_s6;

	fq_t q_s7;

	logic [2:0][32:0] d_c, e_c, ad_c, ae_c;
	logic [2:0][31:0] eye_c, aim_c, cen_c;
	logic [WIDE_W-1:0] a_c, ee_c, bpos_c, bneg_c;
	logic [66:0]       qx_c;
	logic [DISC_W-1:0] p_c, q_c;

	assign en        = !(v_s7 && full);
	assign in_stall  = !en;
	assign push      = v_s7 && !full;
	assign push_data = q_s7;

	always_comb begin
		eye_c = {eye_z, eye_y, eye_x};
		aim_c = {aim_z, aim_y, aim_x};
		cen_c = {center_z, center_y, center_x};
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = {aim_c[k][31], aim_c[k]} - {eye_c[k][31], eye_c[k]};
			e_c[k]  = {eye_c[k][31], eye_c[k]} - {cen_c[k][31], cen_c[k]};
			ad_c[k] = d_s1[k][32] ? 33'(-d_s1[k]) : d_s1[k];
			ae_c[k] = e_s1[k][32] ? 33'(-e_s1[k]) : e_s1[k];
		end
	end

	always_comb begin
		a_c    = '0;
		ee_c   = '0;
		bpos_c = '0;
		bneg_c = '0;
		for (int k = 0; k < 3; k++) begin
			a_c  = a_c + {1'b0, aa_s2[k]};
			ee_c = ee_c + {1'b0, ee_s2[k]};
			if (neg_s2[k]) begin
				bneg_c = bneg_c + {1'b0, ae_s2[k]};
			end else begin
				bpos_c = bpos_c + {1'b0, ae_s2[k]};
			end
		end
	end

	always_comb begin
		qx_c = {1'b0, alch_s5} + {1'b0, ahcl_s5};
		p_c  = {bhh_s5, 66'd0} + ({66'd0, blh_s5} << 34) + {66'd0, bll_s5};
		q_c  = {ahch_s5, 66'd0} + ({65'd0, qx_c} << 33) + {66'd0, alcl_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_c;
			e_s1 <= e_c;
			r_s1 <= sphere_radius;

			for (int k = 0; k < 3; k++) begin
				aa_s2[k]  <= 65'(ad_c[k] * ad_c[k]);
				ee_s2[k]  <= 65'(ae_c[k] * ae_c[k]);
				ae_s2[k]  <= 65'(ad_c[k] * ae_c[k]);
				neg_s2[k] <= d_s1[k][32] ^ e_s1[k][32];
			end
			rr_s2 <= r_s1 * r_s1;

			a_s3    <= a_c;
			ee_s3   <= ee_c;
			bpos_s3 <= bpos_c;
			bneg_s3 <= bneg_c;
			rr_s3   <= rr_s2;

			miss_s4 <= (a_s3 == '0) || (bneg_s3 <= bpos_s3) || (ee_s3 <= {4'd0, rr_s3});
			a_s4    <= a_s3;
			bm_s4   <= bneg_s3 - bpos_s3;
			c_s4    <= ee_s3 - {4'd0, rr_s3};

			miss_s5 <= miss_s4;
			a_s5    <= a_s4;
			bm_s5   <= bm_s4;
			bll_s5  <= bm_s4[32:0] * bm_s4[32:0];
			blh_s5  <= bm_s4[32:0] * bm_s4[65:33];
			bhh_s5  <= bm_s4[65:33] * bm_s4[65:33];
			alcl_s5 <= a_s4[32:0] * c_s4[32:0];
			alch_s5 <= a_s4[32:0] * c_s4[65:33];
			ahcl_s5 <= a_s4[65:33] * c_s4[32:0];
			ahch_s5 <= a_s4[65:33] * c_s4[65:33];

			miss_s6 <= miss_s5;
			a_s6    <= a_s5;
			bm_s6   <= bm_s5;
			p_s6    <= p_c;
			q_s6    <= q_c;

			q_s7.miss <= miss_s6 || (p_s6 < q_s6);
			q_s7.a    <= a_s6;
			q_s7.bm   <= bm_s6;
			q_s7.disc <= p_s6 - q_s6;
		end
	end

endmodule

// ----- hw/rtl/rsi_fifo.sv -----
// ----------------------------------------------------------------------------
// rsi_fifo
// Short queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module rsi_fifo import rsi_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fq_t  push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output fq_t  pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fq_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`include "ray_sphere_intersect_top_assert.svh"

	`RSI_CHECK(a_no_overflow, !(push && full))
	`RSI_CHECK(a_no_underflow, !(pop && !not_empty))
	`RSI_CHECK_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ----- hw/rtl/rsi_back.sv -----
// ----------------------------------------------------------------------------
// rsi_back
// Takes classified rays from the queue, extracts the square root of the
// discriminant one result bit per stage, divides one quotient bit per stage,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  fq_t                pop_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [DIST_W-1:0]  hit_distance
);

	localparam int unsigned SQ_N = DISC_W / 2;
	localparam int unsigned RW   = WIDE_W + 3;
	localparam int unsigned NW   = WIDE_W + 16;
	localparam int unsigned PW   = WIDE_W + DIST_W;

	logic en;

	logic              sq_v_s   [SQ_N+1];
	logic              sq_miss_s[SQ_N+1];
	logic [WIDE_W-1:0] sq_a_s   [SQ_N+1];
	logic [WIDE_W-1:0] sq_bm_s  [SQ_N+1];
	logic [DISC_W-1:0] sq_rad_s [SQ_N+1];
	logic [WIDE_W-1:0] sq_root_s[SQ_N+1];
	logic [RW-1:0]     sq_rem_s [SQ_N+1];

	logic              dv_v_s   [DIST_W+1];
	logic              dv_miss_s[DIST_W+1];
	logic              dv_sat_s [DIST_W+1];
	logic [WIDE_W-1:0] dv_a_s   [DIST_W+1];
	logic [NW-1:0]     dv_rem_s [DIST_W+1];
	logic [DIST_W-1:0] dv_q_s   [DIST_W+1];

	logic              out_v_q;
	logic              hit_q;
	logic [DIST_W-1:0] dist_q;

	logic [WIDE_W-1:0] num_c;

	assign en           = !(out_v_q && out_stall);
	assign pop          = en && not_empty;
	assign out_valid    = out_v_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_miss_s[0] <= pop_data.miss;
			sq_a_s[0]    <= pop_data.a;
			sq_bm_s[0]   <= pop_data.bm;
			sq_rad_s[0]  <= pop_data.disc;
			sq_root_s[0] <= '0;
			sq_rem_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [RW-1:0] cur, trial;
		logic          ge;

		assign cur   = {sq_rem_s[k][RW-3:0], sq_rad_s[k][DISC_W-1:DISC_W-2]};
		assign trial = {1'b0, sq_root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_miss_s[k+1] <= sq_miss_s[k];
				sq_a_s[k+1]    <= sq_a_s[k];
				sq_bm_s[k+1]   <= sq_bm_s[k];
				sq_rad_s[k+1]  <= {sq_rad_s[k][DISC_W-3:0], 2'b00};
				sq_root_s[k+1] <= {sq_root_s[k][WIDE_W-2:0], ge};
				sq_rem_s[k+1]  <= ge ? (cur - trial) : cur;
			end
		end
	end

	assign num_c = sq_bm_s[SQ_N] - sq_root_s[SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_miss_s[0] <= sq_miss_s[SQ_N];
			dv_sat_s[0]  <= ({15'd0, num_c} >= {sq_a_s[SQ_N], 15'd0});
			dv_a_s[0]    <= sq_a_s[SQ_N];
			dv_rem_s[0]  <= {num_c, 16'd0};
			dv_q_s[0]    <= '0;
		end
	end

	for (genvar j = 0; j < DIST_W; j++) begin : g_div
		localparam int unsigned SH = DIST_W - 1 - j;
		logic [PW-1:0] part, rem_w;
		logic          ge;

		assign part  = {{DIST_W{1'b0}}, dv_a_s[j]} << SH;
		assign rem_w = {{(PW - NW){1'b0}}, dv_rem_s[j]};
		assign ge    = (rem_w >= part);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_miss_s[j+1] <= dv_miss_s[j];
				dv_sat_s[j+1]  <= dv_sat_s[j];
				dv_a_s[j+1]    <= dv_a_s[j];
				dv_rem_s[j+1]  <= ge ? NW'(rem_w - part) : dv_rem_s[j];
				dv_q_s[j+1]    <= {dv_q_s[j][DIST_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v_s[DIST_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= !dv_miss_s[DIST_W];
			if (dv_miss_s[DIST_W]) begin
				dist_q <= '0;
			end else if (dv_sat_s[DIST_W]) begin
				dist_q <= '1;
			end else begin
				dist_q <= dv_q_s[DIST_W];
			end
		end
	end

endmodule

// ----- hw/rtl/ray_sphere_intersect_top.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// Ray-sphere intersection accelerator.
//
// A ray is given by an eye point and an aim point in signed Q16.16 and enters
// through the input channel (in_valid, in_stall). One result per ray leaves
// through the output channel (out_valid, out_stall): hit, and the nearer root
// hit_distance in unsigned Q15.16, saturated, zero on a miss. The sphere
// centre and radius are written through the register port; the user must
// write them only while no ray is in flight; the block does not enforce it.
// One ray is taken every cycle while in_stall is low. A ray passes 108
// register stages, the first loaded at its transfer: seven front stages, one
// queue slot, 67 square root stages (a load stage, then one root bit each),
// 32 divide stages (a setup stage, then one quotient bit each) and the output
// register. The square root stages are the longest part of that path.
// Reset empties every stage and the queue and sets the centre to the origin
// and the radius to one. When the receiver stalls, the back holds; the front
// keeps taking rays until the queue fills, then raises in_stall.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top import rsi_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_W-1:0]   eye_x,
	input  logic signed [COORD_W-1:0]   eye_y,
	input  logic signed [COORD_W-1:0]   eye_z,
	input  logic signed [COORD_W-1:0]   aim_x,
	input  logic signed [COORD_W-1:0]   aim_y,
	input  logic signed [COORD_W-1:0]   aim_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic        [DIST_W-1:0]    hit_distance,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic        [3:0]           paddr,
	input  logic        [31:0]          pwdata,
	output logic        [31:0]          prdata,
	output logic                        pready
);

	logic signed [COORD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic        [RADIUS_W-1:0] radius_q;
	reg_idx_t                   idx;

	logic push, full, pop, not_empty;
	fq_t  push_data, pop_data;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_W'(65536);
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_CENTER_X: center_x_q <= pwdata;
				REG_CENTER_Y: center_y_q <= pwdata;
				REG_CENTER_Z: center_z_q <= pwdata;
				REG_RADIUS:   radius_q   <= pwdata[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CENTER_X: prdata = center_x_q;
			REG_CENTER_Y: prdata = center_y_q;
			REG_CENTER_Z: prdata = center_z_q;
			REG_RADIUS:   prdata = {1'b0, radius_q};
			default:      prdata = '0;
		endcase
	end

	rsi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.eye_x         (eye_x),
		.eye_y         (eye_y),
		.eye_z         (eye_z),
		.aim_x         (aim_x),
		.aim_y         (aim_y),
		.aim_z         (aim_z),
		.center_x      (center_x_q),
		.center_y      (center_y_q),
		.center_z      (center_z_q),
		.sphere_radius (radius_q),
		.push          (push),
		.full          (full),
		.push_data     (push_data)
	);

	rsi_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	rsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.hit_distance (hit_distance)
	);

`include "ray_sphere_intersect_top_assert.svh"

	`RSI_CHECK(a_miss_zero, !(out_valid && !hit) || (hit_distance == '0))
	`RSI_CHECK_NEXT(a_cfg_x, psel && penable && pwrite && (idx == REG_CENTER_X),
		center_x_q == $past(pwdata))
	`RSI_CHECK_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(hit) && $stable(hit_distance))

endmodule

// ----- sim/tb_ray_sphere_intersect_top.sv -----
// ----------------------------------------------------------------------------
// Ray-sphere intersection block testbench
// Sends rays through the input channel with random gaps and stalls the result
// channel at random. Every accepted ray is traced by a predictor that uses
// exact wide integer arithmetic. Each result is compared with the oldest
// expected hit flag and distance. The sphere is reprogrammed between phases,
// including its extreme settings.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect_top;
	import rsi_pkg::*;

	typedef struct {
		logic [COORD_W-1:0] eye [3];
		logic [COORD_W-1:0] aim [3];
	} ray_t;

	typedef struct {
		logic              hit;
		logic [DIST_W-1:0] hit_dist;
	} hit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [COORD_W-1:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [COORD_W-1:0] aim_x = 0, aim_y = 0, aim_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic [DIST_W-1:0] hit_distance;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	ray_t ray_q [$];
	hit_t hit_q [$];
	logic [COORD_W-1:0] sphere_center [3];
	logic [RADIUS_W-1:0] sphere_rad;
	int errors = 0;
	int send_gap = 0;
	int recv_stall = 0;
	bit hold_rays = 0;
	bit no_idle = 0;

	ray_sphere_intersect_top i_dut (.*);

	always #10 clk = ~clk;

	function automatic hit_t trace_ray(input ray_t r);
		logic signed [191:0] ev, av, cv, d, e, bsum, asum, csum, bm, disc;
		logic [191:0] root, cand, num, t;
		hit_t res;
		res.hit = 0;
		res.hit_dist = 0;
		bsum = 0;
		asum = 0;
		csum = 0;
		for (int k = 0; k < 3; k++) begin
			ev = $signed(r.eye[k]);
			av = $signed(r.aim[k]);
			cv = $signed(sphere_center[k]);
			d = av - ev;
			e = ev - cv;
			bsum += d * e;
			asum += d * d;
			csum += e * e;
		end
		csum -= $signed({161'b0, sphere_rad}) * $signed({161'b0, sphere_rad});
		if (asum == 0 || bsum >= 0 || csum <= 0)
			return res;
		bm = -bsum;
		disc = bm * bm - asum * csum;
		if (disc < 0)
			return res;
		root = 0;
		for (int i = 66; i >= 0; i--) begin
			cand = root | (192'd1 << i);
			if (cand * cand <= $unsigned(disc))
				root = cand;
		end
		num = $unsigned(bm) - root;
		t = (num << 16) / $unsigned(asum);
		res.hit = 1;
		res.hit_dist = (t > 192'h7FFF_FFFF) ? 31'h7FFF_FFFF : t[DIST_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit busy;
		ray_t r;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				busy = 0;
				r.eye = '{eye_x, eye_y, eye_z};
				r.aim = '{aim_x, aim_y, aim_z};
				hit_q.push_back(trace_ray(r));
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (ray_q.size() > 0 && !hold_rays) begin
					r = ray_q.pop_front();
					{eye_x, eye_y, eye_z} <= {r.eye[0], r.eye[1], r.eye[2]};
					{aim_x, aim_y, aim_z} <= {r.aim[0], r.aim[1], r.aim[2]};
					busy = 1;
					send_gap = no_idle ? 0 : $urandom_range(0, 17);
				end
			end
			in_valid <= busy;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		hit_t want;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hit_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Result transfer with no ray pending: hit=%0b dist=%h",
							hit, hit_distance);
				end else begin
					want = hit_q.pop_front();
					if (hit !== want.hit || hit_distance !== want.hit_dist) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
								want.hit, want.hit_dist, hit, hit_distance);
					end
				end
				recv_stall = no_idle ? 0 : $urandom_range(0, 17);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_CENTER_X: sphere_center[0] = value;
			REG_CENTER_Y: sphere_center[1] = value;
			REG_CENTER_Z: sphere_center[2] = value;
			REG_RADIUS:   sphere_rad = value[RADIUS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [31:0] rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, rad);
	endtask

	task automatic wait_idle();
		while (ray_q.size() > 0 || in_valid || hit_q.size() > 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic add_ray(input logic [31:0] ex, ey, ez, ax, ay, az);
		ray_t r;
		r.eye = '{ex, ey, ez};
		r.aim = '{ax, ay, az};
		ray_q.push_back(r);
	endtask

	// Aimed rays start near the sphere and point roughly at its center.
	task automatic add_random_rays(input int count);
		ray_t r;
		logic [31:0] span, jit;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				for (int k = 0; k < 3; k++) begin
					r.eye[k] = $urandom;
					r.aim[k] = $urandom;
				end
			end else begin
				span = (sphere_rad >> $urandom_range(0, 2)) * $urandom_range(1, 6) + 1;
				jit = sphere_rad >> $urandom_range(0, 8);
				for (int k = 0; k < 3; k++) begin
					r.eye[k] = sphere_center[k] + ($urandom % span)
						- ($urandom_range(0, 1) ? span : 0) * 2;
					r.aim[k] = sphere_center[k] + ($urandom % (jit + 1)) - jit / 2;
				end
			end
			ray_q.push_back(r);
		end
	endtask

	initial begin
		sphere_center = '{0, 0, 0};
		sphere_rad = 31'h0001_0000;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		add_ray(0, 0, 32'hFFFB_0000, 0, 0, 32'hFFFC_0000);
		add_ray(32'h0001_0000, 0, 32'hFFFB_0000, 32'h0001_0000, 0, 32'hFFFC_0000);
		add_ray(0, 0, 32'hFFFB_0000, 0, 0, 32'hFFFB_0000);
		add_ray(0, 0, 0, 0, 0, 32'h0001_0000);
		add_ray(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0);
		add_ray(0, 0, 32'hFFFB_0000, 0, 0, 32'hFFFA_0000);
		add_ray(0, 0, 32'hFFFB_0000, 0, 0, 32'hFFFB_0001);
		add_ray(0, 0, 32'hFFFE_0000, 0, 0, 32'h7FFF_FFFF);
		add_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
		add_ray(0, 32'h0005_0000, 0, 0, 32'h0001_0000, 0);
		add_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		wait_idle();

		add_random_rays(300);
		wait_idle();

		set_sphere($urandom_range(0, 32'h0010_0000), 32'hFFF0_0000, 32'h0003_0000,
			32'h0004_0000);
		add_random_rays(150);
		hold_rays = 1;
		while (hit_q.size() > 0 || in_valid)
			@(posedge clk);
		hold_rays = 0;
		add_random_rays(150);
		wait_idle();

		set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_random_rays(250);
		wait_idle();

		set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		add_random_rays(200);
		wait_idle();

		no_idle = 1;
		set_sphere(0, 0, 0, 32'h0000_0001);
		add_random_rays(250);
		wait_idle();
		no_idle = 0;

		for (int ph = 0; ph < 3; ph++) begin
			set_sphere($urandom, $urandom, $urandom, $urandom_range(1, 32'h0100_0000));
			add_random_rays(200);
			wait_idle();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(40_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
